[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold in the same cycle.
`define MTKD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition must hold in the next cycle.
`define MTKD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mtkd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package mtkd_pkg;

  localparam int IDX_W  = 10;
  localparam int OFS_W  = 22;
  localparam int SKIP_W = OFS_W - 2;

  localparam logic [IDX_W-1:0] IDX_END   = 10'd624;
  localparam logic [IDX_W-1:0] LAST_WORD = 10'd623;
  localparam logic [IDX_W-1:0] MID_OFS   = 10'd397;
  localparam logic [IDX_W-1:0] WRAP_LIM  = 10'd227;

  localparam logic [31:0] MATRIX_A   = 32'h9908_b0df;
  localparam logic [31:0] SEED_MULT  = 32'd1812433253;
  localparam logic [31:0] TEMPER_B   = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C   = 32'hefc6_0000;
  localparam logic [31:0] SEED_RESET = 32'd5489;

  // register index, taken from paddr[2]
  localparam logic REG_SEED   = 1'b0;
  localparam logic REG_OFFSET = 1'b1;

  typedef struct packed {
    logic capture;
    logic seed_init;
    logic seed_mul;
    logic seed_add;
    logic skip_step;
    logic tw_prime;
    logic tw_issue;
    logic tw_done;
    logic rd_issue;
    logic temper;
    logic out_load;
  } mtkd_cmd_t;

  typedef struct packed {
    logic need_draw;
    logic seed_last;
    logic skip_zero;
    logic idx_end;
    logic tw_last;
  } mtkd_sts_t;

  function automatic logic [31:0] mt_temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage
`default_nettype wire

[rtl/mt19937_keystream_descrambler.sv]
`timescale 1ns / 1ps
`default_nettype none
// Item without a new word passes IDLE, CHECK and OUT; drawing a word adds READ and TEMPER (memory read, temper).
// Every 624th draw runs a twist first, one word per cycle through the RAM.
// First item: seeding (serial multiply chain), then the offset skip advances up to 624 words per step,
// plus one twist per 624 words. Result register: out_valid rises in the cycle after the load.
// Reset (rst_n, sync, low) clears control, seed to 5489, offset to 0; state RAM is not cleared.
`include "assert_macros.svh"
module mt19937_keystream_descrambler (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_first,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_plain_byte,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import mtkd_pkg::*;

  logic [31:0]      seed_r;
  logic [OFS_W-1:0] offset_r;
  logic             cfg_wr;
  mtkd_cmd_t        cmd;
  mtkd_sts_t        sts;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r   <= SEED_RESET;
      offset_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_SEED:   seed_r   <= cfg_pwdata;
        REG_OFFSET: offset_r <= cfg_pwdata[OFS_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_SEED:   cfg_prdata = seed_r;
      REG_OFFSET: cfg_prdata = {{(32-OFS_W){1'b0}}, offset_r};
      default:    cfg_prdata = '0;
    endcase
  end

  mtkd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_first  (in_first),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  mtkd_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_data_byte     (in_data_byte),
    .in_first         (in_first),
    .seed             (seed_r),
    .keystream_offset (offset_r),
    .out_plain_byte   (out_plain_byte)
  );

  `MTKD_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after transfer")
  `MTKD_ASSERT_NOW(a_no_overwrite, cmd.out_load, !out_valid || out_ready, "result overwritten")
  `MTKD_ASSERT_NOW(a_twist_at_end, cmd.tw_prime, sts.idx_end, "twist with index in range")
  `MTKD_ASSERT_NOW(a_read_in_range, cmd.rd_issue, !sts.idx_end, "word read past end")

endmodule
`default_nettype wire

[rtl/mtkd_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module mtkd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_first,
  output logic                    in_ready,
  input  wire logic               out_ready,
  output logic                    out_valid,
  input  wire mtkd_pkg::mtkd_sts_t sts,
  output mtkd_pkg::mtkd_cmd_t     cmd
);
  import mtkd_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE      = 12'b0000_0000_0001,
    S_SEED_INIT = 12'b0000_0000_0010,
    S_SEED_MUL  = 12'b0000_0000_0100,
    S_SEED_ADD  = 12'b0000_0000_1000,
    S_SKIP      = 12'b0000_0001_0000,
    S_CHECK     = 12'b0000_0010_0000,
    S_TW_PRIME  = 12'b0000_0100_0000,
    S_TW_RUN    = 12'b0000_1000_0000,
    S_TW_LAST   = 12'b0001_0000_0000,
    S_READ      = 12'b0010_0000_0000,
    S_TEMPER    = 12'b0100_0000_0000,
    S_OUT       = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = in_first ? S_SEED_INIT : S_CHECK;
        end
      end
      S_SEED_INIT: begin
        cmd.seed_init = 1'b1;
        state_nxt     = S_SEED_MUL;
      end
      S_SEED_MUL: begin
        cmd.seed_mul = 1'b1;
        state_nxt    = S_SEED_ADD;
      end
      S_SEED_ADD: begin
        cmd.seed_add = 1'b1;
        state_nxt    = sts.seed_last ? S_SKIP : S_SEED_MUL;
      end
      S_SKIP: begin
        if (sts.skip_zero) begin
          state_nxt = S_CHECK;
        end else if (sts.idx_end) begin
          state_nxt = S_TW_PRIME;
        end else begin
          cmd.skip_step = 1'b1;
        end
      end
      S_CHECK: begin
        if (!sts.need_draw) begin
          state_nxt = S_OUT;
        end else if (sts.idx_end) begin
          state_nxt = S_TW_PRIME;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_TW_PRIME: begin
        cmd.tw_prime = 1'b1;
        state_nxt    = S_TW_RUN;
      end
      S_TW_RUN: begin
        cmd.tw_issue = 1'b1;
        if (sts.tw_last) state_nxt = S_TW_LAST;
      end
      S_TW_LAST: begin
        // last write of the twist lands this cycle
        cmd.tw_done = 1'b1;
        state_nxt   = S_SKIP;
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_TEMPER;
      end
      S_TEMPER: begin
        cmd.temper = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

[rtl/mtkd_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
module mtkd_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire mtkd_pkg::mtkd_cmd_t        cmd,
  output mtkd_pkg::mtkd_sts_t             sts,
  input  wire logic [7:0]                 in_data_byte,
  input  wire logic                       in_first,
  input  wire logic [31:0]                seed,
  input  wire logic [mtkd_pkg::OFS_W-1:0] keystream_offset,
  output logic [7:0]                      out_plain_byte
);
  import mtkd_pkg::*;

  logic [31:0] mem [624];

  logic [7:0]        data_r;
  logic              need_draw_r, need_draw_nxt;
  logic [31:0]       p_r, p_nxt;
  logic [31:0]       m_r;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [SKIP_W-1:0] skip_r, skip_nxt;
  logic [31:0]       key_r, key_nxt;
  logic [1:0]        lane_r, lane_nxt;
  logic [31:0]       rd_a_r, rd_b_r, prev_r;
  logic [IDX_W-1:0]  wk_r;
  logic              wv_r;
  logic [7:0]        out_r;

  logic [31:0]       chain_x;
  logic [63:0]       prod;
  logic [31:0]       seed_word;
  logic [31:0]       tw_y, tw_val;
  logic [IDX_W-1:0]  ra, rb, room, step_a, step_b;
  logic [SKIP_W-1:0] room_w, adv;
  logic              we;
  logic [IDX_W-1:0]  wa;
  logic [31:0]       wd;
  logic [7:0]        key_byte;

  assign chain_x   = p_r ^ (p_r >> 30);
  assign prod      = SEED_MULT * chain_x;
  assign seed_word = m_r + {{(32-IDX_W){1'b0}}, cnt_r};

  // old word k comes from the previous port A read, word k+1 from the current
  assign tw_y   = {prev_r[31], rd_a_r[30:0]};
  assign tw_val = rd_b_r ^ (tw_y >> 1) ^ (tw_y[0] ? MATRIX_A : 32'd0);

  assign step_a = (cnt_r == LAST_WORD) ? '0 : cnt_r + 1'b1;
  assign step_b = (cnt_r < WRAP_LIM) ? cnt_r + MID_OFS : cnt_r - WRAP_LIM;

  always_comb begin
    ra = idx_r;
    rb = step_b;
    if (cmd.tw_prime) begin
      ra = '0;
    end else if (cmd.tw_issue) begin
      ra = step_a;
    end
  end

  always_comb begin
    we = 1'b0;
    wa = wk_r;
    wd = tw_val;
    if (cmd.seed_init) begin
      we = 1'b1;
      wa = '0;
      wd = seed;
    end else if (cmd.seed_add) begin
      we = 1'b1;
      wa = cnt_r;
      wd = seed_word;
    end else if (wv_r) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_a_r <= mem[ra];
    rd_b_r <= mem[rb];
  end

  assign room   = IDX_END - idx_r;
  assign room_w = {{(SKIP_W-IDX_W){1'b0}}, room};
  assign adv    = (skip_r < room_w) ? skip_r : room_w;

  assign key_byte = 8'(key_r >> {lane_r, 3'b000});

  always_comb begin
    need_draw_nxt = need_draw_r;
    p_nxt         = p_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    skip_nxt      = skip_r;
    key_nxt       = key_r;
    lane_nxt      = lane_r;
    if (cmd.capture) begin
      need_draw_nxt = in_first | (lane_r == 2'd0);
    end
    if (cmd.seed_init) begin
      p_nxt    = seed;
      cnt_nxt  = 10'd1;
      skip_nxt = keystream_offset[OFS_W-1:2];
      lane_nxt = keystream_offset[1:0];
      key_nxt  = '0;
    end
    if (cmd.seed_add) begin
      p_nxt   = seed_word;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_WORD) idx_nxt = IDX_END;
    end
    if (cmd.skip_step) begin
      idx_nxt  = idx_r + adv[IDX_W-1:0];
      skip_nxt = skip_r - adv;
    end
    if (cmd.tw_prime) cnt_nxt = '0;
    if (cmd.tw_issue) cnt_nxt = cnt_r + 1'b1;
    if (cmd.tw_done)  idx_nxt = '0;
    if (cmd.temper) begin
      key_nxt       = mt_temper(rd_a_r);
      idx_nxt       = idx_r + 1'b1;
      need_draw_nxt = 1'b0;
    end
    if (cmd.out_load) lane_nxt = lane_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      need_draw_r <= 1'b0;
      idx_r       <= '0;
      skip_r      <= '0;
      key_r       <= '0;
      lane_r      <= '0;
      cnt_r       <= '0;
      wv_r        <= 1'b0;
    end else begin
      need_draw_r <= need_draw_nxt;
      idx_r       <= idx_nxt;
      skip_r      <= skip_nxt;
      key_r       <= key_nxt;
      lane_r      <= lane_nxt;
      cnt_r       <= cnt_nxt;
      wv_r        <= cmd.tw_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture)  data_r <= in_data_byte;
    if (cmd.seed_mul) m_r    <= prod[31:0];
    if (cmd.out_load) out_r  <= data_r ^ key_byte;
    p_r    <= p_nxt;
    prev_r <= rd_a_r;
    wk_r   <= cnt_r;
  end

  assign sts.need_draw = need_draw_r;
  assign sts.seed_last = (cnt_r == LAST_WORD);
  assign sts.tw_last   = (cnt_r == LAST_WORD);
  assign sts.skip_zero = (skip_r == '0);
  assign sts.idx_end   = (idx_r == IDX_END);

  assign out_plain_byte = out_r;

endmodule
`default_nettype wire
